### hw/rtl/gwt_pkg.sv
// Shared types, constants and helpers for the matrix multiply block.
// Used by the configuration, controller, datapath and top-level modules.
`timescale 1ns / 1ps
package gwt_pkg;

	// Store geometry: square stores of MAX_DIM x MAX_DIM elements.
	localparam int MAX_DIM = 16;
	localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W   = $clog2(MAX_DIM + 1);
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int CELLS   = MAX_DIM * MAX_DIM;

	// Field widths.
	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 2 * ELEM_W;
	localparam int ACC_W   = PROD_W + IDX_W;
	localparam int SCL_W   = ACC_W + ELEM_W;
	localparam int TOT_W   = SCL_W + 1;
	localparam int CIDX_W  = 3;

	// Item opcodes.
	typedef enum logic [2:0] {
		OP_LOAD_A  = 3'd0,
		OP_LOAD_B  = 3'd1,
		OP_LOAD_C  = 3'd2,
		OP_COMPUTE = 3'd3,
		OP_READ_C  = 3'd4
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		REG_TRANS_A = 3'd0,
		REG_TRANS_B = 3'd1,
		REG_ROWS_M  = 3'd2,
		REG_COLS_N  = 3'd3,
		REG_INNER_K = 3'd4,
		REG_ALPHA   = 3'd5,
		REG_BETA    = 3'd6
	} reg_idx_t;

	// Result kinds.
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Configuration as seen by the controller and datapath, dimensions clamped.
	typedef struct packed {
		logic                     trans_a;
		logic                     trans_b;
		logic [CNT_W-1:0]         m_dim;
		logic [CNT_W-1:0]         n_dim;
		logic [CNT_W-1:0]         k_dim;
		logic signed [ELEM_W-1:0] alpha;
		logic signed [ELEM_W-1:0] beta;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             wr_c;
		logic             rd_ext;
		logic             mac_issue;
		logic             mac_first;
		logic             mac_last;
		logic             rd_elem;
		logic             scale;
		logic             round;
		logic             clip_clear;
		logic             out_load;
		logic             out_kind;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mac_done;
		logic out_free;
	} stat_t;

	// Saturate a raw dimension to the range 1..MAX_DIM.
	function automatic logic [CNT_W-1:0] clamp_dim(input logic [4:0] d);
		logic [CNT_W-1:0] r;
		if (d == 5'd0) begin
			r = CNT_W'(1);
		end else if (32'(d) > MAX_DIM) begin
			r = CNT_W'(MAX_DIM);
		end else begin
			r = CNT_W'(d);
		end
		return r;
	endfunction

endpackage

### hw/rtl/gwt_cfg.sv
// Configuration register file for the matrix multiply block.
// Depends on gwt_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
module gwt_cfg
	import gwt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CIDX_W-1:0] wr_index,
	input  logic [15:0]       wr_data,
	output cfg_t              cfg
);

	logic                     trans_a_q;
	logic                     trans_b_q;
	logic [4:0]               rows_m_q;
	logic [4:0]               cols_n_q;
	logic [4:0]               inner_k_q;
	logic signed [ELEM_W-1:0] alpha_q;
	logic signed [ELEM_W-1:0] beta_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_a_q <= 1'b0;
			trans_b_q <= 1'b0;
			rows_m_q  <= 5'd16;
			cols_n_q  <= 5'd16;
			inner_k_q <= 5'd16;
			alpha_q   <= 16'sd256;
			beta_q    <= 16'sd0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_TRANS_A: trans_a_q <= wr_data[0];
				REG_TRANS_B: trans_b_q <= wr_data[0];
				REG_ROWS_M:  rows_m_q  <= wr_data[4:0];
				REG_COLS_N:  cols_n_q  <= wr_data[4:0];
				REG_INNER_K: inner_k_q <= wr_data[4:0];
				REG_ALPHA:   alpha_q   <= $signed(wr_data);
				REG_BETA:    beta_q    <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	// Present dimensions clamped to the store size.
	always_comb begin
		cfg.trans_a = trans_a_q;
		cfg.trans_b = trans_b_q;
		cfg.m_dim   = clamp_dim(rows_m_q);
		cfg.n_dim   = clamp_dim(cols_n_q);
		cfg.k_dim   = clamp_dim(inner_k_q);
		cfg.alpha   = alpha_q;
		cfg.beta    = beta_q;
	end

endmodule

### hw/rtl/gwt_ctrl.sv
// Controller state machine: decodes items and sequences the element loops.
// Depends on gwt_pkg for the opcode, command and status types.
`timescale 1ns / 1ps
module gwt_ctrl
	import gwt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] opcode,
	input  cfg_t       cfg,
	input  stat_t      stat,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SCALE,
		ST_ROUND,
		ST_FIN,
		ST_RDOUT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic             accept;
	logic             last_k;
	logic             last_j;
	logic             last_i;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign last_k   = (CNT_W'(k_q) == cfg.k_dim - 1'b1);
	assign last_j   = (CNT_W'(j_q) == cfg.n_dim - 1'b1);
	assign last_i   = (CNT_W'(i_q) == cfg.m_dim - 1'b1);

	// State and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op_t'(opcode))
							OP_COMPUTE: begin
								i_q     <= '0;
								j_q     <= '0;
								k_q     <= '0;
								state_q <= ST_MAC;
							end
							OP_READ_C: state_q <= ST_RDOUT;
							default: ;
						endcase
					end
				end
				ST_MAC: begin
					if (last_k) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (stat.mac_done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_ROUND;
				ST_ROUND: begin
					k_q <= '0;
					if (last_j) begin
						j_q <= '0;
						if (last_i) begin
							state_q <= ST_FIN;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_MAC;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_MAC;
					end
				end
				ST_FIN: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RDOUT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command decode from state and counters.
	always_comb begin
		cmd            = '0;
		cmd.i          = i_q;
		cmd.j          = j_q;
		cmd.k          = k_q;
		cmd.out_kind   = KIND_READ;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(opcode))
						OP_LOAD_A:  cmd.wr_a       = 1'b1;
						OP_LOAD_B:  cmd.wr_b       = 1'b1;
						OP_LOAD_C:  cmd.wr_c       = 1'b1;
						OP_COMPUTE: cmd.clip_clear = 1'b1;
						OP_READ_C:  cmd.rd_ext     = 1'b1;
						default: ;
					endcase
				end
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				cmd.mac_first = (k_q == '0);
				cmd.mac_last  = last_k;
				cmd.rd_elem   = (k_q == '0);
			end
			ST_SCALE: cmd.scale = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_FIN: begin
				cmd.out_load = stat.out_free;
				cmd.out_kind = KIND_DONE;
			end
			ST_RDOUT: cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

	// A result is loaded only when the output register can take it.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded into a busy output register");

	// The accumulator finishes only while the controller waits for it.
	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mac_done |-> (state_q == ST_DRAIN))
		else $error("accumulation finished outside the drain state");

	// Leaving the final state always comes with a result transfer into the output.
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && stat.out_free |=> (state_q == ST_IDLE))
		else $error("compute finish did not return to idle");

endmodule

### hw/rtl/gwt_dp.sv
// Datapath: the three element stores, the multiply-accumulate pipeline,
// scaling, rounding and saturation, and the output register. Uses gwt_pkg.
`timescale 1ns / 1ps
module gwt_dp
	import gwt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  cfg_t                     cfg,
	input  logic [3:0]               row,
	input  logic [3:0]               col,
	input  logic signed [ELEM_W-1:0] value,
	output stat_t                    stat,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     kind,
	output logic signed [ELEM_W-1:0] element,
	output logic                     saturated
);

	logic signed [ELEM_W-1:0] a_mem [CELLS];
	logic signed [ELEM_W-1:0] b_mem [CELLS];
	logic signed [ELEM_W-1:0] c_mem [CELLS];

	logic                     in_range;
	logic [ADDR_W-1:0]        ext_addr;
	logic [ADDR_W-1:0]        a_addr;
	logic [ADDR_W-1:0]        b_addr;
	logic [ADDR_W-1:0]        c_addr;
	logic [ADDR_W-1:0]        c_wr_addr;
	logic signed [ELEM_W-1:0] c_wr_data;
	logic                     c_wr_en;

	logic signed [ELEM_W-1:0] a_rd_s1;
	logic signed [ELEM_W-1:0] b_rd_s1;
	logic                     v_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2;
	logic                     first_s2;
	logic                     last_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;

	logic signed [ELEM_W-1:0] c_rd_q;
	logic                     rd_inside_q;
	logic signed [SCL_W-1:0]  scl_q;
	logic signed [PROD_W-1:0] cb_q;

	logic signed [TOT_W-1:0]  total;
	logic signed [TOT_W-1:0]  rnd;
	logic signed [TOT_W-1:0]  quot;
	logic signed [ELEM_W-1:0] res;
	logic                     clipped;
	logic                     clip_q;

	logic                     out_valid_q;
	logic                     kind_q;
	logic signed [ELEM_W-1:0] element_q;
	logic                     sat_q;

	localparam logic signed [TOT_W-1:0] RND_HALF = TOT_W'(32768);
	localparam logic signed [TOT_W-1:0] Q_MAX    = TOT_W'(32767);
	localparam logic signed [TOT_W-1:0] Q_MIN    = -TOT_W'(32768);

	// Addressing of loads, reads and the element loops.
	assign in_range = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign ext_addr = {IDX_W'(row), IDX_W'(col)};
	assign a_addr   = cfg.trans_a ? {cmd.k, cmd.i} : {cmd.i, cmd.k};
	assign b_addr   = cfg.trans_b ? {cmd.j, cmd.k} : {cmd.k, cmd.j};
	assign c_addr   = cmd.rd_ext ? ext_addr : {cmd.i, cmd.j};

	// Store writes and registered reads for A and B.
	always_ff @(posedge clk) begin
		if (cmd.wr_a && in_range) begin
			a_mem[ext_addr] <= value;
		end
		if (cmd.wr_b && in_range) begin
			b_mem[ext_addr] <= value;
		end
		if (cmd.mac_issue) begin
			a_rd_s1 <= a_mem[a_addr];
			b_rd_s1 <= b_mem[b_addr];
		end
	end

	// C store: one write port for loads and results, one registered read port.
	assign c_wr_en   = (cmd.wr_c && in_range) || cmd.round;
	assign c_wr_addr = cmd.round ? {cmd.i, cmd.j} : ext_addr;
	assign c_wr_data = cmd.round ? res : value;

	always_ff @(posedge clk) begin
		if (c_wr_en) begin
			c_mem[c_wr_addr] <= c_wr_data;
		end
		if (cmd.rd_ext || cmd.rd_elem) begin
			c_rd_q <= c_mem[c_addr];
		end
		if (cmd.rd_ext) begin
			rd_inside_q <= in_range;
		end
	end

	// Multiply-accumulate pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= cmd.mac_issue;
			v_s2   <= v_s1;
			done_q <= v_s2 && last_s2;
		end
	end

	// Multiply-accumulate pipeline payload.
	always_ff @(posedge clk) begin
		first_s1 <= cmd.mac_first;
		last_s1  <= cmd.mac_last;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= a_rd_s1 * b_rd_s1;
		if (v_s2) begin
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	// Scaling by alpha and beta.
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			scl_q <= acc_q * cfg.alpha;
			cb_q  <= c_rd_q * cfg.beta;
		end
	end

	// Sum at Q29.24, round half up to Q8.8 and saturate.
	always_comb begin
		total   = TOT_W'(scl_q) + (TOT_W'(cb_q) <<< 8);
		rnd     = total + RND_HALF;
		quot    = rnd >>> 16;
		clipped = 1'b0;
		if (quot > Q_MAX) begin
			res     = 16'sh7FFF;
			clipped = 1'b1;
		end else if (quot < Q_MIN) begin
			res     = -16'sh8000;
			clipped = 1'b1;
		end else begin
			res = quot[ELEM_W-1:0];
		end
	end

	// Sticky saturation flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
		end else if (cmd.clip_clear) begin
			clip_q <= 1'b0;
		end else if (cmd.round && clipped) begin
			clip_q <= 1'b1;
		end
	end

	// Output register; its valid flag drops once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The flag is captured with the result so it holds while the result waits.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= cmd.out_kind;
			sat_q  <= clip_q;
			if (cmd.out_kind == KIND_DONE || !rd_inside_q) begin
				element_q <= '0;
			end else begin
				element_q <= c_rd_q;
			end
		end
	end

	assign stat.mac_done = done_q;
	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign element       = element_q;
	assign saturated     = sat_q;

	// A product enters the accumulator only after its issued read has passed the read and product registers.
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(cmd.mac_issue, 2))
		else $error("accumulator fed without a matching read");

	// A finished compute reports zero in its element field.
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_DONE |-> element_q == '0)
		else $error("compute finish carries a nonzero element");

	// The sticky flag only rises on a clipped result write.
	a_clip_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(clip_q) |-> $past(cmd.round && clipped))
		else $error("saturation flag set without a clipped result");

endmodule

### hw/rtl/gemm_with_transpose_top.sv
// Top level of the matrix multiply block C = alpha*op(A)*op(B) + beta*C.
// Depends on gwt_pkg, gwt_cfg, gwt_ctrl and gwt_dp.
//
// Usage: items arrive on the in_valid/in_stall channel with opcode, row, col
// and value. Loads of A, B and C are written on transfer and give no result.
// A read of C gives one result (kind 0) via a registered store read.
// A compute gives one result (kind 1) when all M*N elements are written.
// For each element the controller issues K store reads, waits while the
// read, multiply and accumulate stages drain, then scales by alpha and beta,
// then rounds, saturates and writes C. The input channel stalls while a read
// or compute is in progress; loads stream at one item per cycle.
// Results sit in an output register; while out_stall is high the result holds
// and a pending read or compute waits before completing.
// Configuration writes use cfg_valid/cfg_ready and are always ready; they may
// only be issued while the block is idle.
// Reset clears the configuration to its defaults and the saturation flag;
// store contents are undefined until written.
`timescale 1ns / 1ps
module gemm_with_transpose_top
	import gwt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               opcode,
	input  logic [3:0]               row,
	input  logic [3:0]               col,
	input  logic signed [ELEM_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     kind,
	output logic signed [ELEM_W-1:0] element,
	output logic                     saturated,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CIDX_W-1:0]        cfg_index,
	input  logic [15:0]              cfg_data
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	gwt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Controller.
	gwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.cfg      (cfg),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath.
	gwt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.row       (row),
		.col       (col),
		.value     (value),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.element   (element),
		.saturated (saturated)
	);

endmodule

### test/tb_top.sv
// Self-checking testbench for the matrix multiply block gemm_with_transpose_top.
// Depends on gwt_pkg and the block's RTL. Predicts each result from its own copy of the stores.
`timescale 1ns / 1ps
module tb_top;
	import gwt_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 12;

	// A result as the block presents it.
	typedef struct {
		logic                     kind;
		logic signed [ELEM_W-1:0] element;
		logic                     saturated;
	} gemm_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [2:0]               opcode = '0;
	logic [3:0]               row = '0;
	logic [3:0]               col = '0;
	logic signed [ELEM_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     kind;
	logic signed [ELEM_W-1:0] element;
	logic                     saturated;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CIDX_W-1:0]        cfg_index = '0;
	logic [15:0]              cfg_data = '0;

	gemm_with_transpose_top dut (.*);

	always #2 clk = ~clk;

	// Predictor state: the three stores, the flag and the configuration.
	logic signed [15:0] a_mem [MAX_DIM][MAX_DIM];
	logic signed [15:0] b_mem [MAX_DIM][MAX_DIM];
	logic signed [15:0] c_mem [MAX_DIM][MAX_DIM];
	logic               clip_sticky = 1'b0;
	logic               tr_a = 1'b0, tr_b = 1'b0;
	logic [4:0]         dim_m = 5'd16, dim_n = 5'd16, dim_k = 5'd16;
	logic signed [15:0] alpha_q = 16'sd256, beta_q = 16'sd0;

	gemm_result_t pending_results[$];
	int  mismatch_count = 0;
	bit  no_gaps = 1'b0;
	bit  hold_request = 1'b0;
	bit  stall_enable = 1'b1;
	int  hold_left = 0, stall_left = 0, idle_cycles = 0;

	function automatic int dim_eff(logic [4:0] d);
		if (d == 5'd0) return 1;
		if (d > 5'd16) return MAX_DIM;
		return int'(d);
	endfunction

	// Forms the whole C update of one compute and refreshes the sticky flag.
	function automatic void predict_gemm();
		longint acc, total, rounded;
		longint av, bv;
		clip_sticky = 1'b0;
		for (int i = 0; i < dim_eff(dim_m); i++) begin
			for (int j = 0; j < dim_eff(dim_n); j++) begin
				acc = 0;
				for (int k = 0; k < dim_eff(dim_k); k++) begin
					av = tr_a ? a_mem[k][i] : a_mem[i][k];
					bv = tr_b ? b_mem[j][k] : b_mem[k][j];
					acc += av * bv;
				end
				total = acc * longint'(alpha_q) + longint'(beta_q) * longint'(c_mem[i][j]) * 256;
				rounded = (total + 32768) >>> 16;
				if (rounded > 32767) begin
					rounded = 32767;
					clip_sticky = 1'b1;
				end else if (rounded < -32768) begin
					rounded = -32768;
					clip_sticky = 1'b1;
				end
				c_mem[i][j] = 16'(rounded);
			end
		end
	endfunction

	// Applies one accepted item to the predictor and queues its result, if any.
	function automatic void predict_item(logic [2:0] op, logic [3:0] r, logic [3:0] c,
			logic signed [15:0] v);
		gemm_result_t res;
		case (op)
			OP_LOAD_A: a_mem[r][c] = v;
			OP_LOAD_B: b_mem[r][c] = v;
			OP_LOAD_C: c_mem[r][c] = v;
			OP_COMPUTE: begin
				predict_gemm();
				res.kind = KIND_DONE;
				res.element = '0;
				res.saturated = clip_sticky;
				pending_results.push_back(res);
			end
			OP_READ_C: begin
				res.kind = KIND_READ;
				res.element = c_mem[r][c];
				res.saturated = clip_sticky;
				pending_results.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [15:0] random_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'sh7FFF;
		if (r == 1) return 16'sh8000;
		if (r < 6) return 16'($urandom_range(0, 1023)) - 16'sd512;
		return 16'($urandom);
	endfunction

	// Offers one item and waits for its transfer, then inserts a random gap.
	task automatic send_item(logic [2:0] op, logic [3:0] r, logic [3:0] c,
			logic signed [15:0] v);
		int gap;
		in_valid <= 1'b1;
		opcode <= op;
		row <= r;
		col <= c;
		value <= v;
		do @(posedge clk); while (in_stall);
		predict_item(op, r, c, v);
		gap = random_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every expected result has come and the block has settled.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the valid drops for a cycle after each transfer.
	task automatic write_reg(reg_idx_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TRANS_A: tr_a = data[0];
			REG_TRANS_B: tr_b = data[0];
			REG_ROWS_M:  dim_m = data[4:0];
			REG_COLS_N:  dim_n = data[4:0];
			REG_INNER_K: dim_k = data[4:0];
			REG_ALPHA:   alpha_q = data;
			REG_BETA:    beta_q = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Small dimensions keep computes short; a few use the full size.
	function automatic logic [15:0] random_dim();
		logic [15:0] d;
		d = 16'($urandom) & 16'hFFE0;
		if ($urandom_range(0, 9) == 0) return d | 16'($urandom_range(16, 31));
		return d | 16'($urandom_range(0, 4));
	endfunction

	task automatic write_all_regs(logic [15:0] ta, logic [15:0] tb, logic [15:0] m,
			logic [15:0] n, logic [15:0] k, logic [15:0] al, logic [15:0] be);
		write_reg(REG_TRANS_A, ta);
		write_reg(REG_TRANS_B, tb);
		write_reg(REG_ROWS_M, m);
		write_reg(REG_COLS_N, n);
		write_reg(REG_INNER_K, k);
		write_reg(REG_ALPHA, al);
		write_reg(REG_BETA, be);
	endtask

	// Every store entry is written first, so no compute or read sees an unwritten one.
	task automatic test_fill_stores();
		for (int s = 0; s < 3; s++) begin
			for (int i = 0; i < MAX_DIM; i++) begin
				for (int j = 0; j < MAX_DIM; j++) begin
					send_item(3'(s), 4'(i), 4'(j), random_value());
				end
			end
		end
	endtask

	// Directed items: default settings, extremes, unknown opcodes, transposes.
	task automatic test_directed();
		send_item(OP_LOAD_A, 4'd0, 4'd0, 16'sh7FFF);
		send_item(OP_LOAD_B, 4'd15, 4'd15, 16'sh8000);
		send_item(OP_LOAD_C, 4'd15, 4'd0, 16'sh8000);
		send_item(OP_READ_C, 4'd15, 4'd0, 16'shFFFF);
		send_item(3'd5, 4'd3, 4'd3, 16'sh1234);
		send_item(3'd6, 4'd0, 4'd15, 16'sh0000);
		send_item(3'd7, 4'd15, 4'd15, 16'shFFFF);
		send_item(OP_COMPUTE, 4'd15, 4'd15, 16'shFFFF);
		send_item(OP_READ_C, 4'd0, 4'd0, 16'sh0);
		send_item(OP_READ_C, 4'd15, 4'd15, 16'sh0);
		wait_idle();
		write_all_regs(16'hFFFF, 16'h0001, 16'h0000, 16'h001F, 16'h0001, 16'h8000, 16'h7FFF);
		send_item(OP_COMPUTE, 4'd0, 4'd0, 16'sh0);
		send_item(OP_READ_C, 4'd0, 4'd0, 16'sh0);
		send_item(OP_READ_C, 4'd0, 4'd15, 16'sh0);
		wait_idle();
		write_all_regs(16'h0000, 16'hFFFE, 16'h0002, 16'h0003, 16'h0010, 16'h0080, 16'h8000);
		send_item(OP_COMPUTE, 4'd7, 4'd7, 16'sh7FFF);
		send_item(OP_READ_C, 4'd1, 4'd2, 16'sh0);
		wait_idle();
		write_reg(REG_ALPHA, 16'h0000);
		send_item(OP_COMPUTE, 4'd0, 4'd0, 16'sh0);
		send_item(OP_READ_C, 4'd1, 4'd2, 16'sh0);
		wait_idle();
	endtask

	// Random phases, each under fresh random settings.
	task automatic test_random(int phases, int items_per_phase);
		int r;
		for (int p = 0; p < phases; p++) begin
			wait_idle();
			write_all_regs(16'($urandom), 16'($urandom), random_dim(), random_dim(),
				random_dim(), 16'(random_value()), 16'(random_value()));
			no_gaps = (p % 3 == 1);
			for (int n = 0; n < items_per_phase; n++) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					send_item(3'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
						random_value());
				else if (r < 90)
					send_item(OP_READ_C, 4'($urandom), 4'($urandom), 16'($urandom));
				else if (r < 95)
					send_item(OP_COMPUTE, 4'($urandom), 4'($urandom), 16'($urandom));
				else
					send_item(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom),
						16'($urandom));
			end
		end
		no_gaps = 1'b0;
	endtask

	// The receiver holds off for a long stretch while reads keep coming.
	task automatic test_backpressure();
		wait_idle();
		hold_request = 1'b1;
		no_gaps = 1'b1;
		for (int n = 0; n < 20; n++) begin
			send_item(OP_READ_C, 4'($urandom), 4'($urandom), 16'sh0);
			if (n == 9) send_item(OP_COMPUTE, 4'd0, 4'd0, 16'sh0);
		end
		no_gaps = 1'b0;
		// The sender now pauses until every result has come.
		wait_idle();
		send_item(OP_READ_C, 4'd0, 4'd0, 16'sh0);
		wait_idle();
	endtask

	// Receiver: random stalls of varied length, a long hold on request.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_enable && $urandom_range(0, 99) < 20) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compares each result transfer with the oldest expectation.
	always @(posedge clk) begin
		gemm_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("Unexpected result: kind %0d element %0d", kind, element);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (kind !== exp_res.kind) begin
					$error("kind: expected %0d, got %0d", exp_res.kind, kind);
					mismatch_count++;
				end
				if (element !== exp_res.element) begin
					$error("element: expected %0d, got %0d", exp_res.element, element);
					mismatch_count++;
				end
				if (saturated !== exp_res.saturated) begin
					$error("saturated: expected %0d, got %0d", exp_res.saturated, saturated);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_stores();
		test_directed();
		test_backpressure();
		test_random(9, 140);
		wait_idle();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/gwt_pkg.sv
hw/rtl/gwt_cfg.sv
hw/rtl/gwt_ctrl.sv
hw/rtl/gwt_dp.sv
hw/rtl/gemm_with_transpose_top.sv
test/tb_top.sv
